### hw/rtl/robin_hood_hash_table_defines.svh
// assertion macros for the robin hood hash table checker
`ifndef ROBIN_HOOD_HASH_TABLE_DEFINES_SVH
`define ROBIN_HOOD_HASH_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RHH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define RHH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/rhh_pkg.sv
// shared types and constants of the robin hood hash table
package rhh_pkg;

  localparam int LOG2_BUCKETS = 10;
  localparam int VALUE_WIDTH  = 32;
  localparam int DEPTH        = 1 << LOG2_BUCKETS;
  localparam int IDX_W        = LOG2_BUCKETS;
  localparam int DIST_W       = LOG2_BUCKETS + 1;
  localparam int CNT_W        = 11;
  localparam int LOAD_W       = CNT_W + 3;
  localparam int KEY_W        = 32;
  localparam int DATA_W       = 32;
  localparam int SIZE_W       = 4;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = 1;
  localparam int QCNT_W       = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd10;
  localparam logic [SIZE_W-1:0] SIZE_MIN   = 4'd2;
  localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(LOG2_BUCKETS);

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_INSERT = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_HASH,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_LRD,
    B_LEV,
    B_PRD,
    B_PEV,
    B_DRD,
    B_DEV,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [DIST_W-1:0]      distance;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] val;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    func_t                  func;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] val;
    logic [31:0]            hash;
  } q_item_t;

  // handshake between queue and its neighbors
  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/rhh_ram.sv
// generic single write port ram with registered read
module rhh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/rhh_front.sv
// front end: accepts transactions and hashes the key
module rhh_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             func,
  input  logic [rhh_pkg::KEY_W-1:0]  key,
  input  logic [rhh_pkg::DATA_W-1:0] value,
  input  logic                   q_full,
  output logic                   q_push,
  output rhh_pkg::q_item_t       q_item
);
  import rhh_pkg::*;

  front_state_t      state, state_next;
  logic [1:0]        step, step_next;
  logic [31:0]       hash, hash_next;
  func_t             op, op_next;
  logic [KEY_W-1:0]  key_r, key_r_next;
  logic [VALUE_WIDTH-1:0] val_r, val_r_next;
  logic [7:0]        key_byte;

  assign key_byte = key_r[8*step +: 8];
  assign in_stall = (state != F_IDLE);
  assign q_item   = '{func: op, key: key_r, val: val_r, hash: hash};

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    step  <= step_next;
    hash  <= hash_next;
    op    <= op_next;
    key_r <= key_r_next;
    val_r <= val_r_next;
  end

  // accept, one hash byte per cycle, then push
  always_comb begin
    state_next = state;
    step_next  = step;
    hash_next  = hash;
    op_next    = op;
    key_r_next = key_r;
    val_r_next = val_r;
    q_push     = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (in_valid) begin
          op_next    = func_t'(func);
          key_r_next = key;
          val_r_next = VALUE_WIDTH'(value);
          hash_next  = FNV_BASIS;
          step_next  = 2'd0;
          state_next = F_HASH;
        end
      end
      F_HASH: begin
        hash_next = 32'((hash ^ {24'd0, key_byte}) * FNV_PRIME);
        step_next = step + 2'd1;
        if (step == 2'd3) begin
          state_next = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

endmodule

### hw/rtl/rhh_fifo.sv
// short queue between front end and back end
module rhh_fifo (
  input  logic              clk,
  input  logic              rst,
  input  rhh_pkg::q_ctrl_t  ctrl,
  input  rhh_pkg::q_item_t  wr_item,
  output rhh_pkg::q_item_t  rd_item,
  output rhh_pkg::q_stat_t  stat
);
  import rhh_pkg::*;

  q_item_t           mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = ctrl.push && !stat.full;
  assign do_pop     = ctrl.pop && !stat.empty;
  assign rd_item    = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop) count <= count + QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - QCNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_item;
    end
  end

endmodule

### hw/rtl/rhh_back.sv
// back end: probe sequencer over the slot memory
module rhh_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rhh_pkg::SIZE_W-1:0]   cfg_data,
  input  rhh_pkg::q_item_t             q_item,
  input  logic                         q_empty,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [rhh_pkg::DATA_W-1:0]   read_value,
  output logic                         status,
  output logic [rhh_pkg::CNT_W-1:0]    entry_count
);
  import rhh_pkg::*;

  back_state_t            state, state_next;
  logic [SIZE_W-1:0]      size_log2;
  logic [IDX_W-1:0]       idx, idx_next, fpos, fpos_next;
  logic [IDX_W-1:0]       clr_last, clr_last_next;
  logic [DIST_W-1:0]      pc, pc_next;
  func_t                  op, op_next;
  logic [KEY_W-1:0]       cur_key, cur_key_next;
  logic [VALUE_WIDTH-1:0] cur_val, cur_val_next;
  logic [VALUE_WIDTH-1:0] new_val, new_val_next;
  logic [VALUE_WIDTH-1:0] rv, rv_next;
  logic                   hit, hit_next, refused, refused_next, reply, reply_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   out_load;

  logic [SIZE_W-1:0]      size_eff;
  logic [CNT_W-1:0]       nb;
  logic [IDX_W-1:0]       mask, idx_inc;
  logic [LOAD_W-1:0]      load_lhs, load_rhs;
  logic                   is_full;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  entry_t                 ram_wentry, e;
  logic [ENTRY_W-1:0]     ram_rdata;

  rhh_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  assign e = entry_t'(ram_rdata);

  // bucket range from the clamped size
  always_comb begin
    if (size_log2 < SIZE_MIN) size_eff = SIZE_MIN;
    else if (size_log2 > SIZE_MAX) size_eff = SIZE_MAX;
    else size_eff = size_log2;
  end
  assign nb       = CNT_W'(1) << size_eff;
  assign mask     = IDX_W'(nb - CNT_W'(1));
  assign idx_inc  = (idx + IDX_W'(1)) & mask;
  assign load_lhs = (LOAD_W'(count) + LOAD_W'(1)) * LOAD_W'(5);
  assign load_rhs = LOAD_W'(nb) << 2;
  assign is_full  = (load_lhs > load_rhs);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLEAR;
      size_log2 <= SIZE_RESET;
      count     <= '0;
      out_valid <= 1'b0;
      reply     <= 1'b0;
      clr_last  <= '1;
      idx       <= '0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      reply    <= reply_next;
      clr_last <= clr_last_next;
      idx      <= idx_next;
      if (cfg_we) size_log2 <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fpos    <= fpos_next;
    pc      <= pc_next;
    op      <= op_next;
    cur_key <= cur_key_next;
    cur_val <= cur_val_next;
    new_val <= new_val_next;
    rv      <= rv_next;
    hit     <= hit_next;
    refused <= refused_next;
    if (out_load) begin
      found       <= hit;
      read_value  <= DATA_W'(rv);
      status      <= refused;
      entry_count <= count;
    end
  end

  // sequencer
  always_comb begin
    state_next    = state;
    idx_next      = idx;
    fpos_next     = fpos;
    clr_last_next = clr_last;
    pc_next       = pc;
    op_next       = op;
    cur_key_next  = cur_key;
    cur_val_next  = cur_val;
    new_val_next  = new_val;
    rv_next       = rv;
    hit_next      = hit;
    refused_next  = refused;
    reply_next    = reply;
    count_next    = count;
    q_pop         = 1'b0;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = idx;
    ram_wentry    = '{distance: pc, key: cur_key, val: cur_val};

    if (cfg_we) begin
      // new size empties the whole memory
      state_next    = B_CLEAR;
      idx_next      = '0;
      clr_last_next = '1;
      reply_next    = 1'b0;
      count_next    = '0;
    end else begin
      unique case (state)
        B_CLEAR: begin
          ram_we     = 1'b1;
          ram_wentry = '0;
          idx_next   = idx + IDX_W'(1);
          if (idx == clr_last) begin
            count_next = '0;
            state_next = reply ? B_DONE : B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            q_pop        = 1'b1;
            op_next      = q_item.func;
            cur_key_next = q_item.key;
            cur_val_next = q_item.val;
            new_val_next = q_item.val;
            idx_next     = q_item.hash[IDX_W-1:0] & mask;
            pc_next      = DIST_W'(1);
            hit_next     = 1'b0;
            refused_next = 1'b0;
            rv_next      = '0;
            if (q_item.func == FN_CLEAR) begin
              idx_next      = '0;
              clr_last_next = mask;
              reply_next    = 1'b1;
              state_next    = B_CLEAR;
            end else begin
              state_next = B_LRD;
            end
          end
        end
        B_LRD: state_next = B_LEV;
        B_LEV: begin
          if (e.distance == '0 || pc > e.distance) begin
            // key absent
            if (op == FN_INSERT) begin
              if (is_full) begin
                refused_next = 1'b1;
                state_next   = B_DONE;
              end else begin
                count_next = count + CNT_W'(1);
                state_next = B_PEV;
              end
            end else begin
              state_next = B_DONE;
            end
          end else if (e.key == cur_key) begin
            hit_next = 1'b1;
            rv_next  = e.val;
            priority case (op)
              FN_INSERT: begin
                ram_we     = 1'b1;
                ram_wentry = '{distance: e.distance, key: e.key, val: new_val};
                state_next = B_DONE;
              end
              FN_REMOVE: begin
                count_next = count - CNT_W'(1);
                fpos_next  = idx;
                idx_next   = idx_inc;
                state_next = B_DRD;
              end
              default: state_next = B_DONE;
            endcase
          end else begin
            idx_next   = idx_inc;
            pc_next    = pc + DIST_W'(1);
            state_next = B_LRD;
          end
        end
        B_PRD: state_next = B_PEV;
        B_PEV: begin
          idx_next   = idx_inc;
          state_next = B_PRD;
          if (e.distance == '0) begin
            ram_we     = 1'b1;
            state_next = B_DONE;
          end else if (e.distance < pc) begin
            // swap with the richer resident
            ram_we       = 1'b1;
            cur_key_next = e.key;
            cur_val_next = e.val;
            pc_next      = e.distance + DIST_W'(1);
          end else begin
            pc_next = pc + DIST_W'(1);
          end
        end
        B_DRD: state_next = B_DEV;
        B_DEV: begin
          ram_we    = 1'b1;
          ram_waddr = fpos;
          if (e.distance <= DIST_W'(1)) begin
            ram_wentry = '0;
            state_next = B_DONE;
          end else begin
            // shift the follower back one slot
            ram_wentry = '{distance: e.distance - DIST_W'(1), key: e.key, val: e.val};
            fpos_next  = idx;
            idx_next   = idx_inc;
            state_next = B_DRD;
          end
        end
        B_DONE: begin
          if (!out_valid || !out_stall) begin
            if (reply) begin
              hit_next     = 1'b0;
              refused_next = 1'b0;
            end
            out_load   = 1'b1;
            reply_next = 1'b0;
            state_next = B_IDLE;
          end
        end
        default: state_next = B_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/robin_hood_hash_table.sv
// Robin Hood hash table with 32-bit keys, FNV-1a hashing and linear probing.
// The front end accepts a transaction, runs four hash multiply steps and
// pushes it to the queue before it takes the next one; a 2-entry queue feeds
// the back end, which probes the slot memory with a read state and an
// evaluate state per visited slot; insert placement and backward-shift
// removal likewise read and evaluate every moved slot. The slot
// memory has one read and one write port. After reset and after every write
// of size_log2 the back end clears all 1024 slots, one per cycle; a clear-all
// transaction clears the buckets in use (size_log2 clamped to 2..10).
// Transactions are queued meanwhile.
module robin_hood_hash_table (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rhh_pkg::SIZE_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   func,
  input  logic [rhh_pkg::KEY_W-1:0]    key,
  input  logic [rhh_pkg::DATA_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         found,
  output logic [rhh_pkg::DATA_W-1:0]   read_value,
  output logic                         status,
  output logic [rhh_pkg::CNT_W-1:0]    entry_count
);
  import rhh_pkg::*;

  q_item_t wr_item, rd_item;
  q_ctrl_t q_ctrl;
  q_stat_t q_stat;

  // accept and hash
  rhh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .key      (key),
    .value    (value),
    .q_full   (q_stat.full),
    .q_push   (q_ctrl.push),
    .q_item   (wr_item)
  );

  // decoupling queue
  rhh_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (q_ctrl),
    .wr_item (wr_item),
    .rd_item (rd_item),
    .stat    (q_stat)
  );

  // table operations
  rhh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .q_item      (rd_item),
    .q_empty     (q_stat.empty),
    .q_pop       (q_ctrl.pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

### hw/rtl/rhh_checker.sv
// port-level checks of the robin hood hash table
`include "robin_hood_hash_table_defines.svh"

module rhh_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       found,
  input logic [rhh_pkg::DATA_W-1:0] read_value,
  input logic                       status,
  input logic [rhh_pkg::CNT_W-1:0]  entry_count
);
  import rhh_pkg::*;

  // a refused insert never reports a hit
  `RHH_ASSERT_IMP(a_refused_not_found, out_valid && status, !found, "refused insert with found set")
  // a miss carries zero data
  `RHH_ASSERT_IMP(a_miss_zero, out_valid && !found, read_value == '0, "miss with nonzero read_value")
  // the entry count never passes the table depth
  `RHH_ASSERT_IMP(a_count_range, out_valid, entry_count <= CNT_W'(DEPTH), "entry_count out of range")
  // a stalled result stays put
  `RHH_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(entry_count) && $stable(found), "stalled result changed")

endmodule

bind robin_hood_hash_table rhh_checker u_rhh_checker (.*);

### tb/tb_robin_hood_hash_table.sv
// self-checking testbench for the robin hood hash table
`timescale 1ns / 1ps

class rhh_scoreboard;
  localparam int NSLOT = rhh_pkg::DEPTH;

  logic [31:0] tbl_key [NSLOT];
  logic [31:0] tbl_val [NSLOT];
  int unsigned tbl_dist [NSLOT];
  int unsigned entries;
  int unsigned size_sel;

  // expected results, oldest first
  logic [44:0] pending_results [$];
  int errors;

  function new();
    errors = 0;
    size_sel = 10;
    wipe();
  endfunction

  function void wipe();
    for (int i = 0; i < NSLOT; i++) begin
      tbl_key[i] = '0;
      tbl_val[i] = '0;
      tbl_dist[i] = 0;
    end
    entries = 0;
  endfunction

  function void set_size(logic [3:0] s);
    size_sel = s;
    wipe();
  endfunction

  function int unsigned buckets();
    int unsigned s;
    s = size_sel;
    if (s < 2) s = 2;
    if (s > rhh_pkg::LOG2_BUCKETS) s = rhh_pkg::LOG2_BUCKETS;
    return 1 << s;
  endfunction

  function logic [31:0] fnv_hash(logic [31:0] k);
    logic [31:0] h;
    h = 32'd2166136261;
    for (int b = 0; b < 4; b++) h = (h ^ {24'd0, k[8*b +: 8]}) * 32'd16777619;
    return h;
  endfunction

  function int find_slot(logic [31:0] k, int unsigned nb);
    int unsigned m, i, pc;
    m = nb - 1;
    i = fnv_hash(k) & m;
    pc = 1;
    for (int n = 0; n < nb; n++) begin
      if (tbl_dist[i] == 0 || pc > tbl_dist[i]) return -1;
      if (tbl_key[i] == k) return i;
      i = (i + 1) & m;
      pc++;
    end
    return -1;
  endfunction

  function void place(logic [31:0] k, logic [31:0] v, int unsigned nb);
    int unsigned m, i, pc, td;
    logic [31:0] tk, tv;
    m = nb - 1;
    i = fnv_hash(k) & m;
    pc = 1;
    for (int n = 0; n < nb; n++) begin
      if (tbl_dist[i] == 0) begin
        tbl_key[i] = k; tbl_val[i] = v; tbl_dist[i] = pc;
        return;
      end
      // swap out a richer resident
      if (tbl_dist[i] < pc) begin
        tk = tbl_key[i]; tv = tbl_val[i]; td = tbl_dist[i];
        tbl_key[i] = k; tbl_val[i] = v; tbl_dist[i] = pc;
        k = tk; v = tv; pc = td;
      end
      i = (i + 1) & m;
      pc++;
    end
  endfunction

  function void backshift(int unsigned f, int unsigned nb);
    int unsigned m, i;
    m = nb - 1;
    tbl_dist[f] = 0;
    if (entries > 0) entries--;
    i = (f + 1) & m;
    for (int n = 0; n < nb; n++) begin
      if (tbl_dist[i] <= 1) break;
      tbl_key[f] = tbl_key[i];
      tbl_val[f] = tbl_val[i];
      tbl_dist[f] = tbl_dist[i] - 1;
      tbl_dist[i] = 0;
      f = i;
      i = (i + 1) & m;
    end
  endfunction

  // note an accepted input transaction and queue its expected result
  function void note_input(rhh_pkg::func_t fn, logic [31:0] k, logic [31:0] v);
    int unsigned nb;
    int at;
    logic hit, full;
    logic [31:0] rv;
    nb = buckets();
    hit = 0; full = 0; rv = '0; at = -1;
    if (fn == rhh_pkg::FN_CLEAR) begin
      wipe();
    end else begin
      at = find_slot(k, nb);
      if (at >= 0) begin
        hit = 1;
        rv = tbl_val[at];
      end
      if (fn == rhh_pkg::FN_INSERT) begin
        if (at >= 0) tbl_val[at] = v;
        else if (5 * (entries + 1) > 4 * nb) full = 1;
        else begin
          place(k, v, nb);
          entries++;
        end
      end else if (fn == rhh_pkg::FN_REMOVE && at >= 0) begin
        backshift(at, nb);
      end
    end
    pending_results.push_back({hit, rv, full, 11'(entries)});
  endfunction

  // compare one result transaction with the oldest expectation
  function void check_result(logic f, logic [31:0] rv, logic st, logic [10:0] cnt);
    logic [44:0] e;
    if (pending_results.size() == 0) begin
      $display("%0t: unexpected result found=%0d value=%h status=%0d count=%0d",
               $time, f, rv, st, cnt);
      errors++;
      return;
    end
    e = pending_results.pop_front();
    if (e[44] !== f) begin
      $display("%0t: found expected %0d actual %0d", $time, e[44], f);
      errors++;
    end
    if (e[43:12] !== rv) begin
      $display("%0t: read_value expected %h actual %h", $time, e[43:12], rv);
      errors++;
    end
    if (e[11] !== st) begin
      $display("%0t: status expected %0d actual %0d", $time, e[11], st);
      errors++;
    end
    if (e[10:0] !== cnt) begin
      $display("%0t: entry_count expected %0d actual %0d", $time, e[10:0], cnt);
      errors++;
    end
  endfunction
endclass

module tb_robin_hood_hash_table;
  import rhh_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [SIZE_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] func = '0;
  logic [31:0] key = '0;
  logic [31:0] value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic found;
  logic [31:0] read_value;
  logic status;
  logic [10:0] entry_count;

  rhh_scoreboard board = new();
  bit quiet = 0;
  bit sink_idle_on = 1;
  logic [31:0] key_pool [16];

  robin_hood_hash_table DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .found(found),
    .read_value(read_value), .status(status), .entry_count(entry_count)
  );

  always #5 clk = ~clk;

  // result side: check accepted results, stall in random bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        board.check_result(found, read_value, status, entry_count);
      if (quiet || !sink_idle_on) out_stall <= 0;
      else if (out_stall) out_stall <= ($urandom_range(0, 5) != 0);
      else out_stall <= ($urandom_range(0, 9) == 0);
    end
  end

  // send one transaction, optionally after a random idle burst
  task automatic send_op(func_t fn, logic [31:0] k, logic [31:0] v);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    func <= fn;
    key <= k;
    value <= v;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_input(fn, k, v);
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (1100) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] s);
    drain();
    cfg_data <= s;
    cfg_we <= 1;
    @(posedge clk);
    cfg_we <= 0;
    board.set_size(s);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return key_pool[$urandom_range(0, 15)];
  endfunction

  task automatic random_phase(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_op(FN_INSERT, pick_key(), $urandom);
      else if (r < 70) send_op(FN_LOOKUP, pick_key(), $urandom);
      else if (r < 98) send_op(FN_REMOVE, pick_key(), $urandom);
      else send_op(FN_CLEAR, $urandom, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, every operation, full table, absent keys
    send_op(FN_LOOKUP, 32'h0, 32'h0);
    send_op(FN_INSERT, 32'h0, 32'hffffffff);
    send_op(FN_INSERT, 32'hffffffff, 32'h0);
    send_op(FN_LOOKUP, 32'hffffffff, 32'h1234);
    send_op(FN_INSERT, 32'h0, 32'ha5a5a5a5);
    send_op(FN_LOOKUP, 32'h0, 32'h0);
    send_op(FN_REMOVE, 32'h0, 32'h0);
    send_op(FN_REMOVE, 32'h0, 32'h0);
    send_op(FN_CLEAR, 32'hffffffff, 32'hffffffff);
    write_size(4'd2);
    for (int i = 0; i < 5; i++) send_op(FN_INSERT, i, ~i);
    send_op(FN_INSERT, 32'd1, 32'd77);
    send_op(FN_REMOVE, 32'd1, 32'd0);
    send_op(FN_LOOKUP, 32'd2, 32'd0);
    send_op(FN_CLEAR, 32'd0, 32'd0);

    // random phases across sizes, extremes included
    write_size(4'd3);
    random_phase(100);
    write_size(4'd0);
    random_phase(80);
    // hold off until everything has come back
    in_valid <= 0;
    while (board.pending_results.size() != 0) @(posedge clk);
    random_phase(20);
    write_size(4'd10);
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom;
    random_phase(120);
    write_size(4'd15);
    random_phase(60);
    write_size(4'd4);
    random_phase(120);
    quiet = 1;
    random_phase(100);

    drain();
    if (board.errors == 0 && board.pending_results.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/rhh_pkg.sv
hw/rtl/rhh_ram.sv
hw/rtl/rhh_front.sv
hw/rtl/rhh_fifo.sv
hw/rtl/rhh_back.sv
hw/rtl/robin_hood_hash_table.sv
hw/rtl/rhh_checker.sv
tb/tb_robin_hood_hash_table.sv
